[rtl/btat_pkg.sv]
// Shared types and constants of the box track association table.
`default_nettype none

package btat_pkg;

	// Fixed field widths of the item and result payloads.
	localparam int COORD_BITS = 12;
	localparam int MISS_BITS  = 8;
	localparam int SLOT_BITS  = 4;

	// Operation codes of an input item.
	localparam logic [1:0] OP_ADD       = 2'd0;
	localparam logic [1:0] OP_DETECT    = 2'd1;
	localparam logic [1:0] OP_END_FRAME = 2'd2;

	// Kinds of result.
	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_ENTRY = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;

	// Miss limit after reset.
	localparam logic [MISS_BITS-1:0] MISS_LIMIT_RESET = 8'd10;

	// One input item.
	typedef struct packed {
		logic [1:0]            operation;
		logic [COORD_BITS-1:0] box_x;
		logic [COORD_BITS-1:0] box_y;
		logic [COORD_BITS-1:0] box_w;
		logic [COORD_BITS-1:0] box_h;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [1:0]            result_kind;
		logic                  add_accepted;
		logic [SLOT_BITS-1:0]  slot;
		logic [COORD_BITS-1:0] out_x;
		logic [COORD_BITS-1:0] out_y;
		logic [COORD_BITS-1:0] out_w;
		logic [COORD_BITS-1:0] out_h;
		logic [MISS_BITS-1:0]  missed;
		logic                  last;
	} result_t;

	// A box as held in the track and detection memories.
	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] w;
		logic [COORD_BITS-1:0] h;
	} box_t;

	// One entry of the track memory.
	typedef struct packed {
		box_t                 box;
		logic [MISS_BITS-1:0] missed;
	} track_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_TRK,
		S_DET,
		S_WB,
		S_EM_START,
		S_EM_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic trk_add;
		logic trk_keep;
		logic det_write;
		logic work_load;
		logic det_check;
		logic clear_used;
		logic out_add;
		logic add_ok;
		logic out_entry;
		logic out_empty;
		logic out_last;
	} dp_cmd_t;

endpackage

`default_nettype wire

[rtl/btat_dp.sv]
// Datapath: track and detection memories, working track, containment test and result register.
`default_nettype none

module btat_dp #(
	parameter int MAX_TRACKS     = 16,
	parameter int MAX_DETECTIONS = 16,
	localparam int TIW = $clog2(MAX_TRACKS),
	localparam int DIW = $clog2(MAX_DETECTIONS)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [btat_pkg::MISS_BITS-1:0]      cfg_wdata,
	input  wire btat_pkg::item_t                     item,
	input  wire btat_pkg::dp_cmd_t                   cmd,
	input  wire logic [TIW-1:0]                      trk_raddr,
	input  wire logic [TIW-1:0]                      trk_waddr,
	input  wire logic [DIW-1:0]                      det_raddr,
	input  wire logic [DIW-1:0]                      det_waddr,
	input  wire logic [DIW-1:0]                      det_sel,
	input  wire logic [btat_pkg::SLOT_BITS-1:0]      out_slot,
	output logic                                     survive,
	output btat_pkg::result_t                        result,
	output logic                                     result_valid
);

	localparam int CB = btat_pkg::COORD_BITS;
	localparam int MB = btat_pkg::MISS_BITS;

	btat_pkg::box_t   in_box;
	btat_pkg::track_t trk_mem_q [MAX_TRACKS];
	btat_pkg::track_t trk_rd_q;
	btat_pkg::box_t   det_mem_q [MAX_DETECTIONS];
	btat_pkg::box_t   det_rd_q;
	btat_pkg::box_t   work_box_q;
	logic [MB-1:0]    work_miss_q;
	logic             hit_q;
	logic [MAX_DETECTIONS-1:0] used_q;
	logic [MB-1:0]    miss_limit_q;
	logic [MB-1:0]    new_miss;
	logic [CB:0]      cx;
	logic [CB:0]      cy;
	logic [CB:0]      tx_end;
	logic [CB:0]      ty_end;
	logic             centre_in;
	logic             take;
	btat_pkg::result_t res_q;
	logic             res_valid_q;

	assign in_box = '{x: item.box_x, y: item.box_y, w: item.box_w, h: item.box_h};

	// Miss limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_limit_q <= btat_pkg::MISS_LIMIT_RESET;
		end else if (cfg_we) begin
			miss_limit_q <= cfg_wdata;
		end
	end

	// Track memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.trk_add) begin
			trk_mem_q[trk_waddr] <= '{box: in_box, missed: '0};
		end else if (cmd.trk_keep) begin
			trk_mem_q[trk_waddr] <= '{box: work_box_q, missed: new_miss};
		end
		trk_rd_q <= trk_mem_q[trk_raddr];
	end

	// Detection memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.det_write) begin
			det_mem_q[det_waddr] <= in_box;
		end
		det_rd_q <= det_mem_q[det_raddr];
	end

	// The detection centre must lie inside the working box, right and bottom edges excluded.
	always_comb begin
		cx        = {1'b0, det_rd_q.x} + {2'b00, det_rd_q.w[CB-1:1]};
		cy        = {1'b0, det_rd_q.y} + {2'b00, det_rd_q.h[CB-1:1]};
		tx_end    = {1'b0, work_box_q.x} + {1'b0, work_box_q.w};
		ty_end    = {1'b0, work_box_q.y} + {1'b0, work_box_q.h};
		centre_in = (cx >= {1'b0, work_box_q.x}) && (cx < tx_end) &&
		            (cy >= {1'b0, work_box_q.y}) && (cy < ty_end);
		take      = cmd.det_check && !used_q[det_sel] && centre_in;
	end

	// Missed count after this frame and whether the track stays.
	always_comb begin
		if (hit_q) begin
			new_miss = '0;
		end else if (work_miss_q == {MB{1'b1}}) begin
			new_miss = work_miss_q;
		end else begin
			new_miss = work_miss_q + MB'(1);
		end
		survive = hit_q || (new_miss < miss_limit_q);
	end

	// Working track: loaded from memory, replaced by each detection it takes.
	always_ff @(posedge clk) begin
		if (cmd.work_load) begin
			work_box_q  <= trk_rd_q.box;
			work_miss_q <= trk_rd_q.missed;
		end else if (take) begin
			work_box_q <= det_rd_q;
		end
	end

	// Match flag of the working track and used flags of the detections.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			used_q <= '0;
		end else begin
			if (cmd.work_load) begin
				hit_q <= 1'b0;
			end else if (take) begin
				hit_q <= 1'b1;
			end
			if (cmd.clear_used) begin
				used_q <= '0;
			end else if (take) begin
				used_q[det_sel] <= 1'b1;
			end
		end
	end

	// Result register: each result is shown for one cycle.
	always_ff @(posedge clk) begin
		if (cmd.out_add) begin
			res_q <= '{result_kind: btat_pkg::KIND_ADD, add_accepted: cmd.add_ok,
			           slot: out_slot, out_x: '0, out_y: '0, out_w: '0, out_h: '0,
			           missed: '0, last: 1'b1};
		end else if (cmd.out_entry) begin
			res_q <= '{result_kind: btat_pkg::KIND_ENTRY, add_accepted: 1'b0,
			           slot: out_slot, out_x: trk_rd_q.box.x, out_y: trk_rd_q.box.y,
			           out_w: trk_rd_q.box.w, out_h: trk_rd_q.box.h,
			           missed: trk_rd_q.missed, last: cmd.out_last};
		end else if (cmd.out_empty) begin
			res_q <= '{result_kind: btat_pkg::KIND_EMPTY, add_accepted: 1'b0,
			           slot: '0, out_x: '0, out_y: '0, out_w: '0, out_h: '0,
			           missed: '0, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.out_add || cmd.out_entry || cmd.out_empty;
		end
	end

	assign result       = res_q;
	assign result_valid = res_valid_q;

endmodule

`default_nettype wire

[rtl/btat_ctrl.sv]
// Controller: item decode, association sequencing, compaction and table readout.
`default_nettype none

module btat_ctrl #(
	parameter int MAX_TRACKS     = 16,
	parameter int MAX_DETECTIONS = 16,
	localparam int TIW = $clog2(MAX_TRACKS),
	localparam int DIW = $clog2(MAX_DETECTIONS)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [1:0]                      operation,
	input  wire logic                            survive,
	output logic                                 busy,
	output btat_pkg::dp_cmd_t                    cmd,
	output logic [TIW-1:0]                       trk_raddr,
	output logic [TIW-1:0]                       trk_waddr,
	output logic [DIW-1:0]                       det_raddr,
	output logic [DIW-1:0]                       det_waddr,
	output logic [DIW-1:0]                       det_sel,
	output logic [btat_pkg::SLOT_BITS-1:0]       out_slot
);

	localparam int TW = $clog2(MAX_TRACKS + 1);
	localparam int DW = $clog2(MAX_DETECTIONS + 1);

	btat_pkg::state_t state_q, state_d;
	logic [TW-1:0]  tc_q, tc_d;
	logic [DW-1:0]  fc_q, fc_d;
	logic [TIW-1:0] i_q, i_d;
	logic [DIW-1:0] j_q, j_d;
	logic [TW-1:0]  k_q, k_d;
	logic [TIW-1:0] e_q, e_d;
	logic           last_entry;

	// State and counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btat_pkg::S_IDLE;
			tc_q    <= '0;
			fc_q    <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			e_q     <= '0;
		end else begin
			state_q <= state_d;
			tc_q    <= tc_d;
			fc_q    <= fc_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			e_q     <= e_d;
		end
	end

	// Next state, counters and datapath commands.
	always_comb begin
		state_d    = state_q;
		tc_d       = tc_q;
		fc_d       = fc_q;
		i_d        = i_q;
		j_d        = j_q;
		k_d        = k_q;
		e_d        = e_q;
		cmd        = '0;
		busy       = 1'b1;
		trk_raddr  = '0;
		trk_waddr  = k_q[TIW-1:0];
		det_raddr  = '0;
		det_waddr  = fc_q[DIW-1:0];
		det_sel    = j_q;
		out_slot   = '0;
		last_entry = (TW'(e_q) + TW'(1)) == tc_q;

		unique case (state_q)
			btat_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					unique case (operation)
						btat_pkg::OP_ADD: begin
							cmd.out_add = 1'b1;
							if (tc_q != TW'(MAX_TRACKS)) begin
								cmd.trk_add = 1'b1;
								cmd.add_ok  = 1'b1;
								trk_waddr   = tc_q[TIW-1:0];
								out_slot    = btat_pkg::SLOT_BITS'(tc_q);
								tc_d        = tc_q + TW'(1);
							end
						end
						btat_pkg::OP_DETECT: begin
							// A detection beyond the buffer is dropped.
							if (fc_q != DW'(MAX_DETECTIONS)) begin
								cmd.det_write = 1'b1;
								fc_d          = fc_q + DW'(1);
							end
						end
						btat_pkg::OP_END_FRAME: begin
							cmd.clear_used = 1'b1;
							i_d            = '0;
							k_d            = '0;
							if (tc_q == '0) begin
								state_d = btat_pkg::S_EM_START;
							end else begin
								state_d = btat_pkg::S_TRK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			btat_pkg::S_TRK: begin
				// Track i is in the read register; first detection read goes out.
				cmd.work_load = 1'b1;
				j_d           = '0;
				if (fc_q == '0) begin
					state_d = btat_pkg::S_WB;
				end else begin
					state_d = btat_pkg::S_DET;
				end
			end
			btat_pkg::S_DET: begin
				// One detection checked per cycle, the next one read meanwhile.
				cmd.det_check = 1'b1;
				det_raddr     = j_q + DIW'(1);
				j_d           = j_q + DIW'(1);
				if ((DW'(j_q) + DW'(1)) == fc_q) begin
					state_d = btat_pkg::S_WB;
				end
			end
			btat_pkg::S_WB: begin
				// Surviving track goes to the next compacted slot.
				if (survive) begin
					cmd.trk_keep = 1'b1;
					k_d          = k_q + TW'(1);
				end
				trk_raddr = i_q + TIW'(1);
				if ((TW'(i_q) + TW'(1)) == tc_q) begin
					state_d = btat_pkg::S_EM_START;
				end else begin
					i_d     = i_q + TIW'(1);
					state_d = btat_pkg::S_TRK;
				end
			end
			btat_pkg::S_EM_START: begin
				tc_d = k_q;
				fc_d = '0;
				e_d  = '0;
				if (k_q == '0) begin
					cmd.out_empty = 1'b1;
					state_d       = btat_pkg::S_IDLE;
				end else begin
					state_d = btat_pkg::S_EM_OUT;
				end
			end
			btat_pkg::S_EM_OUT: begin
				// One table entry per cycle, the next one read meanwhile.
				cmd.out_entry = 1'b1;
				cmd.out_last  = last_entry;
				out_slot      = btat_pkg::SLOT_BITS'(e_q);
				trk_raddr     = e_q + TIW'(1);
				e_d           = e_q + TIW'(1);
				if (last_entry) begin
					state_d = btat_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = btat_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/box_track_association_table_unit.sv]
// Top level of the box track association table.
// An item is taken when start is high and busy is low. An add answers in the cycle
// after its transfer and a detection gives no result; both leave busy low. An end of
// frame holds busy high while the association runs: each track is read from the
// track memory, then compared with one detection per cycle through the single read
// port of the detection memory, then written back to its compacted slot if it survives.
// The surviving table then streams out one entry per cycle, and the final result is
// on the port in the same cycle as busy falls.
// Each result is on the result port for exactly one cycle with result_valid high;
// the receiver cannot stall it and must take every transfer as it comes.
`default_nettype none

module box_track_association_table_unit #(
	parameter int MAX_TRACKS     = 16,
	parameter int MAX_DETECTIONS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire btat_pkg::item_t            item,
	input  wire logic                       cfg_we,
	input  wire logic [btat_pkg::MISS_BITS-1:0] cfg_wdata,
	output logic                            result_valid,
	output btat_pkg::result_t               result
);

	localparam int TIW = $clog2(MAX_TRACKS);
	localparam int DIW = $clog2(MAX_DETECTIONS);

	btat_pkg::dp_cmd_t            cmd;
	logic [TIW-1:0]               trk_raddr;
	logic [TIW-1:0]               trk_waddr;
	logic [DIW-1:0]               det_raddr;
	logic [DIW-1:0]               det_waddr;
	logic [DIW-1:0]               det_sel;
	logic [btat_pkg::SLOT_BITS-1:0] out_slot;
	logic                         survive;

	btat_ctrl #(
		.MAX_TRACKS     (MAX_TRACKS),
		.MAX_DETECTIONS (MAX_DETECTIONS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (item.operation),
		.survive   (survive),
		.busy      (busy),
		.cmd       (cmd),
		.trk_raddr (trk_raddr),
		.trk_waddr (trk_waddr),
		.det_raddr (det_raddr),
		.det_waddr (det_waddr),
		.det_sel   (det_sel),
		.out_slot  (out_slot)
	);

	btat_dp #(
		.MAX_TRACKS     (MAX_TRACKS),
		.MAX_DETECTIONS (MAX_DETECTIONS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.item         (item),
		.cmd          (cmd),
		.trk_raddr    (trk_raddr),
		.trk_waddr    (trk_waddr),
		.det_raddr    (det_raddr),
		.det_waddr    (det_waddr),
		.det_sel      (det_sel),
		.out_slot     (out_slot),
		.survive      (survive),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

`default_nettype wire

[rtl/btat_checker.sv]
// Port-level checks of the box track association table, bound to the top level.
`default_nettype none

module btat_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire btat_pkg::item_t   item,
	input wire logic              result_valid,
	input wire btat_pkg::result_t result
);

	// An accepted add answers in the next cycle with a final add result.
	a_add_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.operation == btat_pkg::OP_ADD) |=>
		(result_valid && result.result_kind == btat_pkg::KIND_ADD && result.last))
		else $error("add transfer not answered in the next cycle");

	// An accepted end of frame starts the association run.
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.operation == btat_pkg::OP_END_FRAME) |=> busy)
		else $error("end of frame did not raise busy");

	// A result that is not final only appears while a frame is still being read out.
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last) |-> busy)
		else $error("non-final result while idle");

	// Table entries stream out on consecutive cycles with consecutive slots.
	a_entry_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.result_kind == btat_pkg::KIND_ENTRY && !result.last) |=>
		(result_valid && result.result_kind == btat_pkg::KIND_ENTRY &&
		 result.slot == 4'($past(result.slot) + 4'd1)))
		else $error("table readout broke its slot sequence");

endmodule

bind box_track_association_table_unit btat_checker u_btat_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.item         (item),
	.result_valid (result_valid),
	.result       (result)
);

`default_nettype wire
